// ===== hdl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// Shell command tokenizer package
// Shared types and character constants for the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_SINGLE = 2'd1;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    localparam int RESULT_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       byte_valid;
        logic       token_first;
        logic       token_end;
        logic       is_operator;
        logic [1:0] open_quote;
        logic       run_last;
    } res_t;

    typedef struct packed {
        logic       in_word;
        logic       word_started_output;
        logic [1:0] quote_mode;
        logic       pending_op_valid;
        logic [7:0] pending_op_char;
    } lex_state_t;

    function automatic res_t make_res(input logic [7:0] b, input logic v, input logic f,
                                      input logic e, input logic op, input logic [1:0] oq);
        res_t r;
        r.token_byte  = v ? b : 8'd0;
        r.byte_valid  = v;
        r.token_first = f;
        r.token_end   = e;
        r.is_operator = op;
        r.open_quote  = oq;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sct_lexer.sv =====
// ----------------------------------------------------------------------------
// Tokenizer decision logic
// Computes the results and the next lexer state for one input item.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_lexer (
    input  wire logic                kind,
    input  wire logic [7:0]          char_in,
    input  sct_pkg::lex_state_t      cur,
    output sct_pkg::lex_state_t      nxt,
    output sct_pkg::res_t            res0,
    output sct_pkg::res_t            res1,
    output logic [1:0]               res_cnt
);

    logic          is_blank;
    logic          is_op;
    logic          is_pairable;
    logic [1:0]    qcode;
    logic          p_en;
    logic          q_en;
    logic          r_en;
    sct_pkg::res_t p_res;
    sct_pkg::res_t q_res;
    sct_pkg::res_t r_res;
    sct_pkg::res_t end_res;
    sct_pkg::res_t byte_res;
    sct_pkg::res_t op_res;

    always_comb begin
        is_blank    = (char_in == sct_pkg::CH_SPACE) || (char_in == sct_pkg::CH_TAB);
        is_pairable = (char_in == sct_pkg::CH_PIPE) || (char_in == sct_pkg::CH_AMP) ||
                      (char_in == sct_pkg::CH_LT) || (char_in == sct_pkg::CH_GT);
        is_op       = is_pairable || (char_in == sct_pkg::CH_SEMI);
        if (char_in == sct_pkg::CH_SQUOTE) begin
            qcode = sct_pkg::QUOTE_SINGLE;
        end else if (char_in == sct_pkg::CH_DQUOTE) begin
            qcode = sct_pkg::QUOTE_DOUBLE;
        end else begin
            qcode = sct_pkg::QUOTE_NONE;
        end

        end_res  = sct_pkg::make_res(8'd0, 1'b0, !cur.word_started_output, 1'b1, 1'b0,
                                     cur.quote_mode);
        byte_res = sct_pkg::make_res(char_in, 1'b1, !cur.word_started_output, 1'b0, 1'b0,
                                     sct_pkg::QUOTE_NONE);
        op_res   = sct_pkg::make_res(char_in, 1'b1, 1'b1, 1'b1, 1'b1, sct_pkg::QUOTE_NONE);

        p_en  = 1'b0;
        q_en  = 1'b0;
        r_en  = 1'b0;
        p_res = sct_pkg::make_res(cur.pending_op_char, 1'b1, 1'b1, 1'b1, 1'b1,
                                  sct_pkg::QUOTE_NONE);
        q_res = end_res;
        r_res = byte_res;
        nxt   = cur;

        if (kind == sct_pkg::KIND_EOL) begin
            p_en = cur.pending_op_valid;
            q_en = cur.in_word;
            nxt  = '0;
        end else begin
            nxt.pending_op_valid = 1'b0;
            nxt.pending_op_char  = 8'd0;
            if (cur.pending_op_valid && (char_in == cur.pending_op_char) && is_pairable) begin
                p_en  = 1'b1;
                q_en  = 1'b1;
                p_res = sct_pkg::make_res(cur.pending_op_char, 1'b1, 1'b1, 1'b0, 1'b1,
                                          sct_pkg::QUOTE_NONE);
                q_res = sct_pkg::make_res(char_in, 1'b1, 1'b0, 1'b1, 1'b1,
                                          sct_pkg::QUOTE_NONE);
            end else begin
                p_en = cur.pending_op_valid;
                if (cur.in_word) begin
                    if (cur.quote_mode != sct_pkg::QUOTE_NONE) begin
                        if (qcode == cur.quote_mode) begin
                            nxt.quote_mode = sct_pkg::QUOTE_NONE;
                        end else begin
                            r_en = 1'b1;
                            nxt.word_started_output = 1'b1;
                        end
                    end else if (is_blank) begin
                        q_en = 1'b1;
                        nxt.in_word = 1'b0;
                        nxt.word_started_output = 1'b0;
                        nxt.quote_mode = sct_pkg::QUOTE_NONE;
                    end else if (is_op) begin
                        q_en = 1'b1;
                        nxt.in_word = 1'b0;
                        nxt.word_started_output = 1'b0;
                        nxt.quote_mode = sct_pkg::QUOTE_NONE;
                        if (is_pairable) begin
                            nxt.pending_op_valid = 1'b1;
                            nxt.pending_op_char  = char_in;
                        end else begin
                            r_en  = 1'b1;
                            r_res = op_res;
                        end
                    end else if (qcode != sct_pkg::QUOTE_NONE) begin
                        nxt.quote_mode = qcode;
                    end else begin
                        r_en = 1'b1;
                        nxt.word_started_output = 1'b1;
                    end
                end else if (is_blank) begin
                    nxt = nxt;
                end else if (is_op) begin
                    if (is_pairable) begin
                        nxt.pending_op_valid = 1'b1;
                        nxt.pending_op_char  = char_in;
                    end else begin
                        r_en  = 1'b1;
                        r_res = op_res;
                    end
                end else begin
                    nxt.in_word = 1'b1;
                    if (qcode != sct_pkg::QUOTE_NONE) begin
                        nxt.quote_mode = qcode;
                        nxt.word_started_output = 1'b0;
                    end else begin
                        r_en  = 1'b1;
                        r_res = sct_pkg::make_res(char_in, 1'b1, 1'b1, 1'b0, 1'b0,
                                                  sct_pkg::QUOTE_NONE);
                        nxt.word_started_output = 1'b1;
                    end
                end
            end
        end

        res0    = p_en ? p_res : (q_en ? q_res : r_res);
        res1    = (p_en && q_en) ? q_res : r_res;
        res_cnt = 2'({1'b0, p_en} + {1'b0, q_en} + {1'b0, r_en});
        if (res_cnt == 2'd2) begin
            res1.run_last = 1'b1;
        end else begin
            res0.run_last = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sct_fifo.sv =====
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Small queue that takes up to two results a cycle and delivers one.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_fifo #(
    parameter int DEPTH = sct_pkg::RESULT_FIFO_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [1:0]    push_cnt,
    input  sct_pkg::res_t      push0,
    input  sct_pkg::res_t      push1,
    input  wire logic          pop,
    output sct_pkg::res_t      head,
    output logic               not_empty,
    output logic               room2
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sct_pkg::res_t  mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  wr_ptr_plus1;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    assign not_empty    = (count_reg != '0);
    assign room2        = (count_reg <= CW'(DEPTH - 2));
    assign head         = mem_reg[rd_ptr_reg];
    assign do_pop       = pop && not_empty;
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push_cnt == 2'd1) begin
            wr_ptr_next = wr_ptr_plus1;
        end else if (push_cnt == 2'd2) begin
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
        end
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = CW'(count_reg + CW'(push_cnt) - CW'(do_pop));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/shell_command_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Shell command tokenizer
// Streaming lexer that splits a command line into word and operator tokens.
// ----------------------------------------------------------------------------
// The input channel (s_) takes one request per character, or an end-of-line
// request that flushes any held operator or open word and returns the lexer
// to its idle state. The result channel (m_) delivers one token byte or end
// marker per transfer, with first, end, operator and open-quote flags, and
// run_last on the last result caused by each input request.
// An accepted request is held in an input register until the queue has room
// for two results; its results are then written into the four-entry result
// queue and show on the m_ side right away. One input request is taken every
// cycle while the queue has room for two results; the m_ side drains one
// result per cycle while m_ready is high, so the sustained input rate is one
// character per cycle when each character causes at most one result, and
// the queue drain sets the rate when characters cause two.
// When the receiver stalls, the queue fills and s_ready falls until space
// for two results is free again. Reset empties the queue and the input
// register and clears all lexer state.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_command_tokenizer #(
    parameter int FIFO_DEPTH = sct_pkg::RESULT_FIFO_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_kind,
    input  wire logic [7:0] s_char_in,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_token_byte,
    output logic            m_byte_valid,
    output logic            m_token_first,
    output logic            m_token_end,
    output logic            m_is_operator,
    output logic [1:0]      m_open_quote,
    output logic            m_run_last
);

    logic                in_vld_reg;
    logic                in_kind_reg;
    logic [7:0]          in_char_reg;
    logic                advance;
    logic                room2;
    sct_pkg::lex_state_t state_reg;
    sct_pkg::lex_state_t state_next;
    sct_pkg::res_t       res0;
    sct_pkg::res_t       res1;
    sct_pkg::res_t       head;
    logic [1:0]          res_cnt;
    logic [1:0]          push_cnt;

    assign advance  = in_vld_reg && room2;
    assign s_ready  = !in_vld_reg || advance;
    assign push_cnt = advance ? res_cnt : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            state_reg  <= '0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_char_reg <= s_char_in;
        end
    end

    sct_lexer u_lexer (
        .kind    (in_kind_reg),
        .char_in (in_char_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    sct_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .pop       (m_ready),
        .head      (head),
        .not_empty (m_valid),
        .room2     (room2)
    );

    assign m_token_byte  = head.token_byte;
    assign m_byte_valid  = head.byte_valid;
    assign m_token_first = head.token_first;
    assign m_token_end   = head.token_end;
    assign m_is_operator = head.is_operator;
    assign m_open_quote  = head.open_quote;
    assign m_run_last    = head.run_last;

endmodule

`default_nettype wire
